// ----- sv/dvl_pkg.sv -----
// dvl_pkg: types, constants and helpers shared by the diffuse vertex lighting block.
// No dependencies; every other file of the block imports it.
`default_nettype none

package dvl_pkg;

	localparam int DEFAULT_MAX_LIGHTS = 8;
	localparam int FRAC_BITS          = 14;
	localparam int VEC_W              = 16;
	localparam int COL_W              = 8;
	localparam int LIGHT_IDX_W        = 3;
	localparam int NUM_LIGHTS_W       = 3;
	localparam int PROD_W             = 2 * VEC_W;
	localparam int DOT_W              = PROD_W + 2;
	localparam int INT_W              = 15;
	localparam int SCALED_W           = COL_W + INT_W;
	localparam int COLOR_MAX          = 255;
	localparam int HALF_LSB           = 1 << (FRAC_BITS - 1);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_VERTEX = 1'b1;

	localparam logic [INT_W-1:0] INTENSITY_MAX = {INT_W{1'b1}};

	typedef struct packed {
		logic                    op;
		logic [LIGHT_IDX_W-1:0]  light_index;
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
		logic signed [VEC_W-1:0] vec_z;
		logic [COL_W-1:0]        col_red;
		logic [COL_W-1:0]        col_green;
		logic [COL_W-1:0]        col_blue;
	} dvl_in_t;

	typedef struct packed {
		logic [COL_W-1:0] out_red;
		logic [COL_W-1:0] out_green;
		logic [COL_W-1:0] out_blue;
	} dvl_out_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} vec3_t;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} rgb_t;

	// Lights that can be in use: limited by the table and by the 3-bit count.
	function automatic int lane_count(input int max_lights);
		int n;
		n = max_lights - 1;
		if (n > (1 << NUM_LIGHTS_W) - 1) begin
			n = (1 << NUM_LIGHTS_W) - 1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- sv/diffuse_vertex_lighting_top.sv -----
// diffuse_vertex_lighting_top: top level of the diffuse vertex lighting block.
// Depends on dvl_pkg, dvl_light_table, dvl_intensity and dvl_shade.
`default_nettype none

// Per-vertex Lambertian lighting with up to seven directional lights plus an
// ambient term. A load request (op = OP_LOAD) writes one light-table entry
// (eye-space direction, Q1.14, and 8-bit RGB colour) in the cycle it is
// accepted and produces no result; indexes past the table are dropped. A
// vertex request (op = OP_VERTEX) carries a Q1.14 normal and produces one
// saturated RGB result. num_lights selects how many table entries act as
// lights; the entry at that index is the ambient colour (clamped to the
// last usable entry). The datapath is a five-stage pipeline: normal-by-
// direction products, dot sum and intensity clamp, colour scaling, channel
// sum, then round/saturate into the output register. One request is taken
// every cycle unless the pipe is full and the output side is stalled; a
// vertex result passes through every stage register in order before it is
// presented at the output. Every stage has its own valid bit, so bubbles
// close up under back-pressure, and in_ready follows out_ready through a
// short combinational chain. A vertex sees every load accepted before it.
// The table resets to zero; no clearing pass is needed. num_lights may only
// be written while no vertex is in flight.
module diffuse_vertex_lighting_top import dvl_pkg::*; #(
	parameter int MAX_LIGHTS = DEFAULT_MAX_LIGHTS,
	localparam int NUM_LANES = lane_count(MAX_LIGHTS)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire dvl_in_t                 in_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output dvl_out_t                     out_data,
	input  wire logic                    cfg_wr_en,
	input  wire logic [NUM_LIGHTS_W-1:0] cfg_wr_data
);

	// request decode: loads terminate at the table, vertices enter the pipe
	logic  tbl_wr_en;
	logic  vtx_valid;
	vec3_t req_vec;
	rgb_t  req_col;

	vec3_t [NUM_LANES-1:0] lane_dir;
	rgb_t  [NUM_LANES-1:0] lane_col;
	logic  [NUM_LANES-1:0] lane_en;
	rgb_t                  ambient;

	// intensity -> shade hand-off
	logic                            int_valid;
	logic                            sh_ready;
	logic [NUM_LANES-1:0][INT_W-1:0] int_lane;
	rgb_t [NUM_LANES-1:0]            int_col;
	rgb_t                            int_amb;

	assign req_vec   = '{x: in_data.vec_x, y: in_data.vec_y, z: in_data.vec_z};
	assign req_col   = '{red: in_data.col_red, green: in_data.col_green,
	                     blue: in_data.col_blue};
	assign tbl_wr_en = in_valid && in_ready && (in_data.op == OP_LOAD);
	assign vtx_valid = in_valid && (in_data.op == OP_VERTEX);

	dvl_light_table #(.MAX_LIGHTS(MAX_LIGHTS)) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (tbl_wr_en),
		.wr_index    (in_data.light_index),
		.wr_dir      (req_vec),
		.wr_col      (req_col),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.lane_dir    (lane_dir),
		.lane_col    (lane_col),
		.lane_en     (lane_en),
		.ambient     (ambient)
	);

	// stages 1-2
	dvl_intensity #(.MAX_LIGHTS(MAX_LIGHTS)) u_intensity (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (vtx_valid),
		.in_ready     (in_ready),
		.normal       (req_vec),
		.lane_dir     (lane_dir),
		.lane_col     (lane_col),
		.lane_en      (lane_en),
		.ambient      (ambient),
		.out_valid    (int_valid),
		.out_ready    (sh_ready),
		.lane_int     (int_lane),
		.lane_col_out (int_col),
		.ambient_out  (int_amb)
	);

	// stages 3-5, output register
	dvl_shade #(.MAX_LIGHTS(MAX_LIGHTS)) u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (int_valid),
		.in_ready  (sh_ready),
		.lane_int  (int_lane),
		.lane_col  (int_col),
		.ambient   (int_amb),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	// a draining output frees every stage back to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	// input can only block when the whole pipe is full and the output stalls
	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input blocked without output back-pressure");

	// intensity results held while the shade stages stall
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(int_valid && !sh_ready) |=>
			(int_valid && $stable(int_lane) && $stable(int_col) && $stable(int_amb)))
		else $error("intensity stage changed under stall");
`endif

endmodule

`default_nettype wire

// ----- sv/dvl_light_table.sv -----
// dvl_light_table: light direction/colour table, light count register, lane fan-out.
// Depends on dvl_pkg.
`default_nettype none

module dvl_light_table import dvl_pkg::*; #(
	parameter int MAX_LIGHTS = DEFAULT_MAX_LIGHTS,
	localparam int NUM_LANES = lane_count(MAX_LIGHTS),
	localparam int IDX_W     = $clog2(MAX_LIGHTS)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [LIGHT_IDX_W-1:0]        wr_index,
	input  wire vec3_t                         wr_dir,
	input  wire rgb_t                          wr_col,
	input  wire logic                          cfg_wr_en,
	input  wire logic [NUM_LIGHTS_W-1:0]       cfg_wr_data,
	output vec3_t [NUM_LANES-1:0]              lane_dir,
	output rgb_t  [NUM_LANES-1:0]              lane_col,
	output logic  [NUM_LANES-1:0]              lane_en,
	output rgb_t                               ambient
);

	vec3_t dir_q [MAX_LIGHTS];
	rgb_t  col_q [MAX_LIGHTS];
	logic [NUM_LIGHTS_W-1:0] num_lights_q;
	logic [NUM_LIGHTS_W-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_lights_q <= '0;
			for (int i = 0; i < MAX_LIGHTS; i++) begin
				dir_q[i] <= '0;
				col_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				num_lights_q <= cfg_wr_data;
			end
			// loads past the end of the table are dropped
			if (wr_en && (int'(wr_index) < MAX_LIGHTS)) begin
				dir_q[IDX_W'(wr_index)] <= wr_dir;
				col_q[IDX_W'(wr_index)] <= wr_col;
			end
		end
	end

	always_comb begin
		count = (num_lights_q > NUM_LIGHTS_W'(NUM_LANES)) ?
			NUM_LIGHTS_W'(NUM_LANES) : num_lights_q;
		ambient = col_q[IDX_W'(count)];
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_dir[i] = dir_q[i];
			lane_col[i] = col_q[i];
			lane_en[i]  = NUM_LIGHTS_W'(i) < count;
		end
	end

endmodule

`default_nettype wire

// ----- sv/dvl_intensity.sv -----
// dvl_intensity: stages 1-2, per-lane dot products and clamped, rounded intensity.
// Depends on dvl_pkg.
`default_nettype none

module dvl_intensity import dvl_pkg::*; #(
	parameter int MAX_LIGHTS = DEFAULT_MAX_LIGHTS,
	localparam int NUM_LANES = lane_count(MAX_LIGHTS)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire vec3_t                        normal,
	input  wire vec3_t [NUM_LANES-1:0]        lane_dir,
	input  wire rgb_t  [NUM_LANES-1:0]        lane_col,
	input  wire logic  [NUM_LANES-1:0]        lane_en,
	input  wire rgb_t                         ambient,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [NUM_LANES-1:0][INT_W-1:0]   lane_int,
	output rgb_t [NUM_LANES-1:0]              lane_col_out,
	output rgb_t                              ambient_out
);

	logic v_s1, v_s2;
	logic en_s1, en_s2;

	logic signed [PROD_W-1:0] px_s1 [NUM_LANES];
	logic signed [PROD_W-1:0] py_s1 [NUM_LANES];
	logic signed [PROD_W-1:0] pz_s1 [NUM_LANES];
	logic [NUM_LANES-1:0]     en_lane_s1;
	rgb_t [NUM_LANES-1:0]     col_s1;
	rgb_t                     amb_s1;

	logic [NUM_LANES-1:0][INT_W-1:0] int_s2;
	rgb_t [NUM_LANES-1:0]            col_s2;
	rgb_t                            amb_s2;
	logic [NUM_LANES-1:0][INT_W-1:0] int_next;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				px_s1[i] <= PROD_W'($signed(normal.x) * $signed(lane_dir[i].x));
				py_s1[i] <= PROD_W'($signed(normal.y) * $signed(lane_dir[i].y));
				pz_s1[i] <= PROD_W'($signed(normal.z) * $signed(lane_dir[i].z));
			end
			en_lane_s1 <= lane_en;
			col_s1     <= lane_col;
			amb_s1     <= ambient;
		end
	end

	// a disabled lane or dot <= 0 gives no light; otherwise round half up and clamp to Q1.14 max
	always_comb begin
		logic signed [DOT_W-1:0] dot;
		logic signed [DOT_W-1:0] rnd;
		logic [DOT_W-FRAC_BITS-1:0] q;
		for (int i = 0; i < NUM_LANES; i++) begin
			dot = DOT_W'(px_s1[i]) + DOT_W'(py_s1[i]) + DOT_W'(pz_s1[i]);
			rnd = dot + DOT_W'(HALF_LSB);
			q   = rnd[DOT_W-1:FRAC_BITS];
			if (!en_lane_s1[i] || dot <= 0) begin
				int_next[i] = '0;
			end else if (|q[DOT_W-FRAC_BITS-1:INT_W]) begin
				int_next[i] = INTENSITY_MAX;
			end else begin
				int_next[i] = q[INT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			int_s2 <= int_next;
			col_s2 <= col_s1;
			amb_s2 <= amb_s1;
		end
	end

	assign out_valid    = v_s2;
	assign lane_int     = int_s2;
	assign lane_col_out = col_s2;
	assign ambient_out  = amb_s2;

endmodule

`default_nettype wire

// ----- sv/dvl_shade.sv -----
// dvl_shade: stages 3-5, colour scaling, per-channel sum with ambient, round and saturate.
// Depends on dvl_pkg.
`default_nettype none

module dvl_shade import dvl_pkg::*; #(
	parameter int MAX_LIGHTS = DEFAULT_MAX_LIGHTS,
	localparam int NUM_LANES = lane_count(MAX_LIGHTS),
	localparam int ACC_W     = SCALED_W + $clog2(NUM_LANES + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [NUM_LANES-1:0][INT_W-1:0] lane_int,
	input  wire rgb_t [NUM_LANES-1:0]           lane_col,
	input  wire rgb_t                           ambient,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output dvl_out_t                            out_data
);

	logic v_s3, v_s4, v_s5;
	logic en_s3, en_s4, en_s5;

	logic [NUM_LANES-1:0][2:0][SCALED_W-1:0] sc_s3;
	logic [2:0][COL_W-1:0]                   amb_s3;
	logic [2:0][ACC_W-1:0]                   acc_s4;
	logic [2:0][ACC_W-1:0]                   acc_next;
	logic [2:0][COL_W-1:0]                   res_next;
	dvl_out_t                                out_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// channel order in the packed view: [2] red, [1] green, [0] blue
	always_ff @(posedge clk) begin
		logic [2:0][COL_W-1:0] ch;
		if (en_s3) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				ch = lane_col[i];
				for (int c = 0; c < 3; c++) begin
					sc_s3[i][c] <= SCALED_W'(ch[c] * lane_int[i]);
				end
			end
			amb_s3 <= ambient;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_next[c] = ACC_W'({amb_s3[c], {FRAC_BITS{1'b0}}});
			for (int i = 0; i < NUM_LANES; i++) begin
				acc_next[c] = acc_next[c] + ACC_W'(sc_s3[i][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) acc_s4 <= acc_next;
	end

	always_comb begin
		logic [ACC_W:0] rnd;
		logic [ACC_W-FRAC_BITS:0] v;
		for (int c = 0; c < 3; c++) begin
			rnd = {1'b0, acc_s4[c]} + (ACC_W+1)'(HALF_LSB);
			v   = rnd[ACC_W:FRAC_BITS];
			res_next[c] = (|v[ACC_W-FRAC_BITS:COL_W]) ? COL_W'(COLOR_MAX) : v[COL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) out_s5 <= res_next;
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

endmodule

`default_nettype wire
